### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ON(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed outside reset");

// Check a property on every clock edge, reset included.
`define ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### hdl/ohmt_pkg.sv
// ----------------------------------------------------------------------------
// ohmt_pkg
// Types and codes shared by the message-type parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ohmt_pkg;

  // Parse phase, one-hot.
  typedef enum logic [5:0] {
    PH_FIRST   = 6'b000001,
    PH_LENGTH  = 6'b000010,
    PH_SKIP    = 6'b000100,
    PH_SERVICE = 6'b001000,
    PH_TYPE    = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  // Result of one parse step.
  typedef struct packed {
    logic       valid;
    logic [7:0] message_type;
    logic       parse_status;
  } result_t;

endpackage

### hdl/options_header_message_type_parser.sv
// ----------------------------------------------------------------------------
// options_header_message_type_parser
// Finds the message-type byte of option-headed telematics packets.
// ----------------------------------------------------------------------------
// Feed packet bytes in order, one request per byte, with last_byte set on
// the final byte. If bit 7 of the first byte is set it is an options header:
// each set flag bit below OPTION_FIELDS announces a field (a length byte and
// that many bytes) that is skipped, then a service-type byte, then the
// message type. If bit 7 is clear the first byte is the service type. Each
// packet yields exactly one result: the message type with parse_status 0 as
// soon as it arrives, or parse_status 1 with message_type 0 on the final
// byte if it never came. Bytes after the message type are dropped. The block
// takes one byte per cycle: a byte is captured in an input register, its
// parse step runs while it is held there and any result lands in the output
// register. Input stalls only when a byte that yields a result meets a full
// output register whose result is not being taken; the parse-state update is
// the loop that sets this rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module options_header_message_type_parser import ohmt_pkg::*; #(
  parameter int OPTION_FIELDS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] message_type,
  output logic       parse_status
);

  // Input register: holds one captured byte awaiting its parse step.
  logic       held;
  logic [7:0] held_byte;
  logic       held_last;

  result_t step_result;
  logic    out_free;
  logic    advance;

  // Advance the held byte unless it yields a result that cannot be stored.
  assign advance    = held && (!step_result.valid || out_free);
  assign byte_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (byte_ready) begin
      held <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      held_byte <= data_byte;
      held_last <= last_byte;
    end
  end

  ohmt_parse_core #(
    .OPTION_FIELDS (OPTION_FIELDS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (held_byte),
    .last_byte (held_last),
    .result    (step_result)
  );

  // Load the output register only for bytes that produce a result.
  ohmt_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && step_result.valid),
    .load_result  (step_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .message_type (message_type),
    .parse_status (parse_status)
  );

endmodule

### hdl/ohmt_parse_core.sv
// ----------------------------------------------------------------------------
// ohmt_parse_core
// Per-byte parse state and its update; yields at most one result per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohmt_parse_core import ohmt_pkg::*; #(
  parameter int OPTION_FIELDS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output result_t    result
);

  localparam int IDX_W = $clog2(OPTION_FIELDS + 1);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    phase_t           phase;
  } seek_t;

  phase_t                   parse_phase, parse_phase_next;
  logic [OPTION_FIELDS-1:0] field_flags, field_flags_next;
  logic [IDX_W-1:0]         field_index, field_index_next;
  logic [7:0]               skip_count, skip_count_next;
  logic [IDX_W-1:0]         index_inc;
  seek_t                    seek_res;

  // Find the lowest announced field at or above start; service byte if none.
  function automatic seek_t seek(input logic [OPTION_FIELDS-1:0] flags,
                                 input logic [IDX_W-1:0] start);
    seek_t s;
    s.index = IDX_W'(OPTION_FIELDS);
    s.phase = PH_SERVICE;
    for (int i = OPTION_FIELDS - 1; i >= 0; i--) begin
      if (flags[i] && (IDX_W'(i) >= start)) begin
        s.index = IDX_W'(i);
        s.phase = PH_LENGTH;
      end
    end
    return s;
  endfunction

  always_comb begin
    parse_phase_next  = parse_phase;
    field_flags_next  = field_flags;
    field_index_next  = field_index;
    skip_count_next   = skip_count;
    index_inc         = field_index + IDX_W'(1);
    seek_res          = '0;
    result.valid        = 1'b0;
    result.message_type = data_byte;
    result.parse_status = STATUS_OK;

    case (parse_phase)
      PH_FIRST: begin
        if (data_byte[7]) begin
          field_flags_next = data_byte[OPTION_FIELDS-1:0];
          seek_res         = seek(data_byte[OPTION_FIELDS-1:0], '0);
          field_index_next = seek_res.index;
          parse_phase_next = seek_res.phase;
        end else begin
          parse_phase_next = PH_TYPE;
        end
      end
      PH_LENGTH: begin
        skip_count_next  = data_byte;
        field_index_next = index_inc;
        if (data_byte == 8'd0) begin
          seek_res         = seek(field_flags, index_inc);
          field_index_next = seek_res.index;
          parse_phase_next = seek_res.phase;
        end else begin
          parse_phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_count_next = skip_count - 8'd1;
        if (skip_count_next == 8'd0) begin
          seek_res         = seek(field_flags, field_index);
          field_index_next = seek_res.index;
          parse_phase_next = seek_res.phase;
        end
      end
      PH_SERVICE: parse_phase_next = PH_TYPE;
      PH_TYPE: begin
        result.valid     = 1'b1;
        parse_phase_next = PH_DONE;
      end
      PH_DONE: ;
      default: begin
        parse_phase_next = PH_FIRST;
        field_flags_next = '0;
        field_index_next = '0;
        skip_count_next  = '0;
      end
    endcase

    // End of packet: report too short if the type never came, then clear.
    if (last_byte) begin
      if (parse_phase_next != PH_DONE) begin
        result.valid        = 1'b1;
        result.message_type = 8'd0;
        result.parse_status = STATUS_SHORT;
      end
      parse_phase_next = PH_FIRST;
      field_flags_next = '0;
      field_index_next = '0;
      skip_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_FIRST;
      field_flags <= '0;
      field_index <= '0;
      skip_count  <= '0;
    end else if (step) begin
      parse_phase <= parse_phase_next;
      field_flags <= field_flags_next;
      field_index <= field_index_next;
      skip_count  <= skip_count_next;
    end
  end

endmodule

### hdl/ohmt_out_reg.sv
// ----------------------------------------------------------------------------
// ohmt_out_reg
// Result register with valid/ready toward the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohmt_out_reg import ohmt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    load_result,
  output logic       free,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] message_type,
  output logic       parse_status
);

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      message_type <= load_result.message_type;
      parse_status <= load_result.parse_status;
    end
  end

endmodule

### hdl/ohmt_checker.sv
// ----------------------------------------------------------------------------
// ohmt_checker
// Port-level checks of the message-type parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ohmt_checker import ohmt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       byte_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] message_type,
  input logic       parse_status
);

  // A waiting result holds its value.
  `ASSERT_ON(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(message_type) && $stable(parse_status))

  // A too-short report carries a zero type.
  `ASSERT_ON(a_short_zero, clk, rst, result_valid && parse_status == STATUS_SHORT |-> message_type == 8'd0)

  // Input stalls only behind a full, untaken result.
  `ASSERT_ON(a_stall_cause, clk, rst, !byte_ready |-> result_valid && !result_ready)

  // Reset empties both registers.
  `ASSERT_ALL(a_reset_empty, clk, rst |=> !result_valid && byte_ready)

endmodule

bind options_header_message_type_parser ohmt_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_ready   (byte_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .message_type (message_type),
  .parse_status (parse_status)
);
